// ===== sv/wpwr_pkg.sv =====
`timescale 1ns / 1ps
package wpwr_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int WEIGHT_BITS = 16;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W = WEIGHT_BITS + IDX_W;
    localparam int DP_W  = SUM_W + 1;

    // fixed field widths of the channels
    localparam int OP_W      = 2;
    localparam int IN_WGT_W  = 16;
    localparam int RND_W     = 31;
    localparam int STATUS_W  = 3;
    localparam int PICK_W    = 6;
    localparam int REM_W     = 7;
    localparam int BITCNT_W  = $clog2(RND_W);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_DRAW  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED  = 3'd0,
        ST_PICKED  = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ALU_IDLE  = 3'd0,
        ALU_CLR   = 3'd1,
        ALU_ADD   = 3'd2,
        ALU_START = 3'd3,
        ALU_MOD   = 3'd4
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        logic    rnd_bit;
    } t_alu_ctl;

    typedef struct packed {
        logic zero;
        logic hit;
    } t_alu_sts;

endpackage

// ===== sv/wpwr_chan_if.sv =====
`timescale 1ns / 1ps
interface wpwr_req_if;
    import wpwr_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [IN_WGT_W-1:0] weight;
    logic [RND_W-1:0]    random_value;

    modport source (output valid, operation, weight, random_value, input ready);
    modport sink   (input valid, operation, weight, random_value, output ready);
endinterface

interface wpwr_rsp_if;
    import wpwr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PICK_W-1:0]   picked_index;
    logic [REM_W-1:0]    remaining_count;

    modport source (output valid, status, picked_index, remaining_count, input ready);
    modport sink   (input valid, status, picked_index, remaining_count, output ready);
endinterface

// ===== sv/wpwr_ram.sv =====
`timescale 1ns / 1ps
module wpwr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/wpwr_alu.sv =====
`timescale 1ns / 1ps
module wpwr_alu (
    input  logic                         i_clk,
    input  wpwr_pkg::t_alu_ctl           i_ctl,
    input  logic [wpwr_pkg::WEIGHT_BITS-1:0] i_weight,
    output wpwr_pkg::t_alu_sts           o_sts
);
    import wpwr_pkg::*;

    logic [SUM_W-1:0] r_acc, n_acc;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SUM_W-1:0] r_rem, n_rem;

    logic [DP_W-1:0] w_a;
    logic [DP_W-1:0] w_b;
    logic            w_cin;
    logic [DP_W:0]   w_full;
    logic [DP_W-1:0] w_shift;

    // one adder serves accumulation and the restoring remainder step
    assign w_shift = {r_rem, i_ctl.rnd_bit};

    always_comb begin
        w_a   = {1'b0, r_acc};
        w_b   = {{(DP_W-WEIGHT_BITS){1'b0}}, i_weight};
        w_cin = 1'b0;
        if (i_ctl.op == ALU_MOD) begin
            w_a   = w_shift;
            w_b   = ~{1'b0, r_sum};
            w_cin = 1'b1;
        end
    end

    assign w_full = {1'b0, w_a} + {1'b0, w_b} + {{DP_W{1'b0}}, w_cin};

    always_comb begin
        n_acc = r_acc;
        n_sum = r_sum;
        n_rem = r_rem;
        case (i_ctl.op)
            ALU_CLR: begin
                n_acc = '0;
            end
            ALU_ADD: begin
                n_acc = w_full[SUM_W-1:0];
            end
            ALU_START: begin
                n_sum = r_acc;
                n_acc = '0;
                n_rem = '0;
            end
            ALU_MOD: begin
                // carry out means the shifted remainder reached the sum
                if (w_full[DP_W]) begin
                    n_rem = w_full[SUM_W-1:0];
                end else begin
                    n_rem = w_shift[SUM_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_sum <= n_sum;
        r_rem <= n_rem;
    end

    // hit: reduced value lies below the running upper bound after this add
    assign o_sts.zero = (r_acc == '0);
    assign o_sts.hit  = (r_rem < w_full[SUM_W-1:0]);
endmodule

// ===== sv/weighted_pick_without_replacement.sv =====
`timescale 1ns / 1ps
// channel  direction  fields
// i_req    in         operation, weight, random_value
// o_rsp    out        status, picked_index, remaining_count
//
// load, clear and a draw on an empty table answer in the cycle after the request is taken.
// a draw makes two passes over the weight ram through its single read port and,
// between them, a 31-step bit-serial remainder in the shared adder; when all
// remaining weights are zero it ends after the first pass.
// reset is synchronous active low, clears counts and present bits, no clearing pass.
// a request is taken only when idle and the response register is free or draining.
module weighted_pick_without_replacement (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wpwr_req_if.sink   i_req,
    wpwr_rsp_if.source o_rsp
);
    import wpwr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_MOD  = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_loaded, n_loaded;
    logic [CNT_W-1:0]        r_remaining, n_remaining;
    logic [MAX_ENTRIES-1:0]  r_present, n_present;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic                    r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]        r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]        r_first, n_first;
    logic                    r_have_first, n_have_first;
    logic [RND_W-1:0]        r_rnd, n_rnd;
    logic [BITCNT_W-1:0]     r_bit_cnt, n_bit_cnt;
    logic                    r_out_vld, n_out_vld;
    t_status                 r_out_status, n_out_status;
    logic [IDX_W-1:0]        r_out_pick, n_out_pick;
    logic [CNT_W-1:0]        r_out_rem, n_out_rem;

    logic                    w_acc;
    logic                    w_fin;
    logic [IDX_W-1:0]        w_fin_idx;
    logic                    w_ram_we;
    logic [WEIGHT_BITS-1:0]  w_ram_rdata;
    logic [WEIGHT_BITS-1:0]  w_wgt;
    logic [IN_WGT_W+WEIGHT_BITS-1:0] w_wgt_ext;
    logic [IDX_W+PICK_W-1:0] w_pick_ext;
    logic [CNT_W+REM_W-1:0]  w_rem_ext;
    logic                    w_more;
    t_alu_ctl                w_alu_ctl;
    t_alu_sts                w_alu_sts;

    assign w_wgt_ext = {{WEIGHT_BITS{1'b0}}, i_req.weight};
    assign w_wgt     = w_wgt_ext[WEIGHT_BITS-1:0];
    assign w_more    = (r_idx < r_loaded);

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_vld || o_rsp.ready);
    assign w_acc       = i_req.valid && i_req.ready;

    wpwr_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_loaded[IDX_W-1:0]),
        .i_wdata (w_wgt),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    wpwr_alu u_alu (
        .i_clk    (i_clk),
        .i_ctl    (w_alu_ctl),
        .i_weight (w_ram_rdata),
        .o_sts    (w_alu_sts)
    );

    always_comb begin
        n_state      = r_state;
        n_loaded     = r_loaded;
        n_remaining  = r_remaining;
        n_present    = r_present;
        n_idx        = r_idx;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_first      = r_first;
        n_have_first = r_have_first;
        n_rnd        = r_rnd;
        n_bit_cnt    = r_bit_cnt;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_pick   = r_out_pick;
        n_out_rem    = r_out_rem;
        w_fin        = 1'b0;
        w_fin_idx    = r_first;
        w_ram_we     = 1'b0;
        w_alu_ctl    = '{op: ALU_IDLE, rnd_bit: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_req.operation)
                        OP_LOAD: begin
                            n_out_vld  = 1'b1;
                            n_out_pick = '0;
                            if (r_loaded >= CNT_W'(MAX_ENTRIES)) begin
                                n_out_status = ST_FULL;
                                n_out_rem    = r_remaining;
                            end else begin
                                w_ram_we                       = 1'b1;
                                n_present[r_loaded[IDX_W-1:0]] = 1'b1;
                                n_loaded                       = r_loaded + 1'b1;
                                n_remaining                    = r_remaining + 1'b1;
                                n_out_status                   = ST_LOADED;
                                n_out_rem                      = r_remaining + 1'b1;
                            end
                        end
                        OP_DRAW: begin
                            if (r_remaining == '0) begin
                                n_out_vld    = 1'b1;
                                n_out_status = ST_EMPTY;
                                n_out_pick   = '0;
                                n_out_rem    = r_remaining;
                            end else begin
                                n_rnd          = i_req.random_value;
                                n_idx          = '0;
                                n_first        = '0;
                                n_have_first   = 1'b0;
                                w_alu_ctl.op   = ALU_CLR;
                                n_state        = S_SUM;
                            end
                        end
                        default: begin
                            // unused code three clears as well
                            n_present    = '0;
                            n_loaded     = '0;
                            n_remaining  = '0;
                            n_out_vld    = 1'b1;
                            n_out_status = ST_CLEARED;
                            n_out_pick   = '0;
                            n_out_rem    = '0;
                        end
                    endcase
                end
            end
            S_SUM: begin
                if (w_more) begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IDX_W-1:0];
                end
                if (r_rd_vld && r_present[r_rd_idx]) begin
                    w_alu_ctl.op = ALU_ADD;
                    if (!r_have_first) begin
                        n_first      = r_rd_idx;
                        n_have_first = 1'b1;
                    end
                end
                if (!r_rd_vld && !w_more) begin
                    if (w_alu_sts.zero) begin
                        // all remaining weights zero: first present entry wins
                        w_fin     = 1'b1;
                        w_fin_idx = r_first;
                    end else begin
                        w_alu_ctl.op = ALU_START;
                        n_bit_cnt    = '0;
                        n_state      = S_MOD;
                    end
                end
            end
            S_MOD: begin
                w_alu_ctl.op      = ALU_MOD;
                w_alu_ctl.rnd_bit = r_rnd[RND_W-1];
                n_rnd             = {r_rnd[RND_W-2:0], 1'b0};
                if (r_bit_cnt == BITCNT_W'(RND_W - 1)) begin
                    n_idx   = '0;
                    n_state = S_SCAN;
                end else begin
                    n_bit_cnt = r_bit_cnt + 1'b1;
                end
            end
            S_SCAN: begin
                if (w_more) begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[IDX_W-1:0];
                end
                if (r_rd_vld && r_present[r_rd_idx]) begin
                    w_alu_ctl.op = ALU_ADD;
                    if (w_alu_sts.hit) begin
                        w_fin     = 1'b1;
                        w_fin_idx = r_rd_idx;
                    end
                end else if (!r_rd_vld && !w_more) begin
                    w_fin     = 1'b1;
                    w_fin_idx = r_first;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_fin) begin
            n_present[w_fin_idx] = 1'b0;
            n_remaining          = r_remaining - 1'b1;
            n_out_vld            = 1'b1;
            n_out_status         = ST_PICKED;
            n_out_pick           = w_fin_idx;
            n_out_rem            = r_remaining - 1'b1;
            n_rd_vld             = 1'b0;
            n_state              = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= '0;
            r_remaining <= '0;
            r_present   <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_remaining <= n_remaining;
            r_present   <= n_present;
            r_rd_vld    <= n_rd_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_first      <= n_first;
        r_have_first <= n_have_first;
        r_rnd        <= n_rnd;
        r_bit_cnt    <= n_bit_cnt;
        r_out_status <= n_out_status;
        r_out_pick   <= n_out_pick;
        r_out_rem    <= n_out_rem;
    end

    assign w_pick_ext = {{PICK_W{1'b0}}, r_out_pick};
    assign w_rem_ext  = {{REM_W{1'b0}}, r_out_rem};

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.picked_index    = w_pick_ext[PICK_W-1:0];
    assign o_rsp.remaining_count = w_rem_ext[REM_W-1:0];

`ifndef SYNTH
    a_rem_le_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining <= r_loaded)
        else $error("remaining count above load count");

    a_rem_popcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_present) == 32'(r_remaining))
        else $error("remaining count disagrees with present bits");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready)
        else $error("request taken while a draw is in progress");

    a_draw_removes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_fin) |=> (r_remaining == $past(r_remaining) - 1'b1))
        else $error("picked entry not removed");
`endif
endmodule
